// ===== rtl/core/fuc_pkg.sv =====
package fuc_pkg;

    // Frame marker and escape byte values
    localparam logic [7:0] HDR_BYTE     = 8'hFD;
    localparam logic [7:0] TRL_BYTE     = 8'hFF;
    localparam logic [7:0] ESC_BYTE     = 8'hFE;
    localparam logic [7:0] ESC_LIT_FE   = 8'hFC;
    localparam logic [7:0] ESC_LIT_FF   = 8'hFD;
    localparam logic [7:0] ESC_OFFSET   = 8'd2;

    // Default frame length limit
    localparam int MAX_FRAME_BYTES_DEF = 255;

    // Job queue between front and back; depth must be a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Frame verdict codes
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_HEADER  = 2'd1,
        ST_BAD_TRAILER = 2'd2,
        ST_TOO_LONG    = 2'd3
    } status_t;

    // Result slots of one job, in emit order
    localparam int SLOT_D0   = 0;
    localparam int SLOT_D1   = 1;
    localparam int SLOT_STAT = 2;
    localparam int NUM_SLOTS = 3;

    // Work handed from front to back for one input transaction
    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic [7:0]           d0;
        logic [7:0]           d1;
        status_t              status;
        logic [7:0]           length;
    } job_t;

endpackage

// ===== rtl/core/frame_unescape_check_top.sv =====
// Byte-stuffing frame decoder and checker.
// Input channel: in_valid / in_stall with in_byte and frame_end; one raw
// byte per transaction, frame_end marking the last raw byte of a frame.
// Output channel: out_valid / out_stall with out_byte, is_status,
// frame_status, frame_length and run_last. Each input transaction gives
// zero to three result transactions: a header, held 0xFE or unescaped
// byte; the current byte; and, on frame_end, one status transaction;
// run_last marks the last of them. Results pass the job queue, then the
// output register. The front decodes one byte per cycle unless the queue
// is full; the back drains one result per cycle from a four-entry job
// queue unless stalled, so the sustained rate is one byte per cycle while
// each byte gives at most one result; a byte with several results holds
// the queue head until all are loaded. Reset clears the queue and
// out_valid and waits for a frame header. On a receiver stall the output
// register holds, the queue fills and in_stall rises at four waiting jobs.
module frame_unescape_check_top #(
    parameter int MAX_FRAME_BYTES = fuc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       frame_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       is_status,
    output logic [1:0] frame_status,
    output logic [7:0] frame_length,
    output logic       run_last
);

    fuc_pkg::job_t push_job, head_job;
    logic          push, pop, full, not_empty;

    assign in_stall = full;

    fuc_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_byte    (in_byte),
        .frame_end  (frame_end),
        .queue_full (full),
        .push       (push),
        .push_job   (push_job)
    );

    fuc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head_job  (head_job)
    );

    fuc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .not_empty    (not_empty),
        .head_job     (head_job),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .is_status    (is_status),
        .frame_status (frame_status),
        .frame_length (frame_length),
        .run_last     (run_last)
    );

endmodule

// ===== rtl/core/fuc_front.sv =====
module fuc_front #(
    parameter int MAX_FRAME_BYTES = fuc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [7:0]        in_byte,
    input  logic              frame_end,
    input  logic              queue_full,
    output logic              push,
    output fuc_pkg::job_t     push_job
);

    localparam int         LEN_CAP_INT = (MAX_FRAME_BYTES < 255) ? MAX_FRAME_BYTES : 255;
    localparam logic [7:0] LEN_CAP     = LEN_CAP_INT[7:0];

    logic            accept;
    logic            start_reg, start_next;
    logic            esc_reg, esc_next;
    fuc_pkg::status_t err_reg, err_next;
    logic [7:0]      cnt_reg, cnt_next;
    fuc_pkg::job_t   job;

    assign accept   = in_valid && !queue_full;
    assign push     = accept && (job.mask != '0);
    assign push_job = job;

    // Per-byte decode: up to two data slots and a status slot
    always_comb
    begin
        logic want0, want1, consumed;
        logic [7:0] byte0, byte1;
        start_next = start_reg;
        esc_next   = esc_reg;
        err_next   = err_reg;
        cnt_next   = cnt_reg;
        want0      = 1'b0;
        want1      = 1'b0;
        consumed   = 1'b0;
        byte0      = '0;
        byte1      = in_byte;

        if (start_reg)
        begin
            start_next = 1'b0;
            esc_next   = 1'b0;
            err_next   = fuc_pkg::ST_OK;
            cnt_next   = '0;
            if (in_byte != fuc_pkg::HDR_BYTE)
                err_next = fuc_pkg::ST_BAD_HEADER;
            else
            begin
                want0 = 1'b1;
                byte0 = in_byte;
            end
        end
        else if (err_reg != fuc_pkg::ST_OK)
            esc_next = 1'b0;
        else if (esc_reg)
        begin
            // resolve the held escape byte
            esc_next = 1'b0;
            if (in_byte == fuc_pkg::ESC_LIT_FE || in_byte == fuc_pkg::ESC_LIT_FF)
            begin
                consumed = 1'b1;
                if (frame_end)
                    err_next = fuc_pkg::ST_BAD_TRAILER;
                else
                begin
                    want0 = 1'b1;
                    byte0 = in_byte + fuc_pkg::ESC_OFFSET;
                end
            end
            else
            begin
                want0 = 1'b1;
                byte0 = fuc_pkg::ESC_BYTE;
            end
        end

        // first data slot against the length limit
        if (want0)
        begin
            if (err_next != fuc_pkg::ST_OK)
                want0 = 1'b0;
            else if (cnt_next >= LEN_CAP)
            begin
                err_next = fuc_pkg::ST_TOO_LONG;
                esc_next = 1'b0;
                want0    = 1'b0;
            end
            else
                cnt_next = cnt_next + 8'd1;
        end

        if (start_reg)
        begin
            if (frame_end && err_next == fuc_pkg::ST_OK)
                err_next = fuc_pkg::ST_BAD_TRAILER;
        end
        else if (err_reg == fuc_pkg::ST_OK && !consumed && err_next == fuc_pkg::ST_OK)
        begin
            // current byte in the frame body or as trailer
            if (frame_end)
            begin
                if (in_byte != fuc_pkg::TRL_BYTE)
                    err_next = fuc_pkg::ST_BAD_TRAILER;
                else
                    want1 = 1'b1;
            end
            else if (in_byte == fuc_pkg::ESC_BYTE)
                esc_next = 1'b1;
            else
                want1 = 1'b1;
        end

        // second data slot against the length limit
        if (want1)
        begin
            if (cnt_next >= LEN_CAP)
            begin
                err_next = fuc_pkg::ST_TOO_LONG;
                esc_next = 1'b0;
                want1    = 1'b0;
            end
            else
                cnt_next = cnt_next + 8'd1;
        end

        job.mask                     = '0;
        job.mask[fuc_pkg::SLOT_D0]   = want0;
        job.mask[fuc_pkg::SLOT_D1]   = want1;
        job.mask[fuc_pkg::SLOT_STAT] = frame_end;
        job.d0                       = byte0;
        job.d1                       = byte1;
        job.status                   = err_next;
        job.length                   = cnt_next;

        // frame end returns to the idle frame state
        if (frame_end)
        begin
            start_next = 1'b1;
            esc_next   = 1'b0;
            err_next   = fuc_pkg::ST_OK;
            cnt_next   = '0;
        end
    end

    // Frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= 1'b1;
            esc_reg   <= 1'b0;
            err_reg   <= fuc_pkg::ST_OK;
            cnt_reg   <= '0;
        end
        else if (accept)
        begin
            start_reg <= start_next;
            esc_reg   <= esc_next;
            err_reg   <= err_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/fuc_queue.sv =====
module fuc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fuc_pkg::job_t push_job,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output fuc_pkg::job_t head_job
);

    fuc_pkg::job_t                    mem [fuc_pkg::QUEUE_DEPTH];
    logic [fuc_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [fuc_pkg::QUEUE_CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == fuc_pkg::QUEUE_CNT_W'(fuc_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_job  = mem[rd_ptr_reg];

    // Occupancy update
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + fuc_pkg::QUEUE_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - fuc_pkg::QUEUE_CNT_W'(1);
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + fuc_pkg::QUEUE_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + fuc_pkg::QUEUE_PTR_W'(1);
            count_reg <= count_next;
        end
    end

    // Job storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== rtl/core/fuc_back.sv =====
module fuc_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          not_empty,
    input  fuc_pkg::job_t head_job,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    out_byte,
    output logic          is_status,
    output logic [1:0]    frame_status,
    output logic [7:0]    frame_length,
    output logic          run_last
);

    logic [fuc_pkg::NUM_SLOTS-1:0] done_reg, done_next;
    logic [fuc_pkg::NUM_SLOTS-1:0] remaining, sel;
    logic                          load, sel_last;
    logic                          valid_reg, valid_next;
    logic [7:0]                    byte_reg, byte_next;
    logic                          stat_reg, stat_next;
    fuc_pkg::status_t              code_reg, code_next;
    logic [7:0]                    len_reg, len_next;
    logic                          last_reg, last_next;

    assign remaining = head_job.mask & ~done_reg;
    assign load      = not_empty && (!valid_reg || !out_stall);
    assign sel       = remaining & (~remaining + fuc_pkg::NUM_SLOTS'(1));
    assign sel_last  = ((remaining & ~sel) == '0);
    assign pop       = load && sel_last;

    assign out_valid    = valid_reg;
    assign out_byte     = byte_reg;
    assign is_status    = stat_reg;
    assign frame_status = code_reg;
    assign frame_length = len_reg;
    assign run_last     = last_reg;

    // Pick the next slot of the head job for the output register
    always_comb
    begin
        done_next  = done_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        stat_next  = stat_reg;
        code_next  = code_reg;
        len_next   = len_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            last_next  = sel_last;
            byte_next  = '0;
            stat_next  = 1'b0;
            code_next  = fuc_pkg::ST_OK;
            len_next   = '0;
            if (sel[fuc_pkg::SLOT_D0])
                byte_next = head_job.d0;
            else if (sel[fuc_pkg::SLOT_D1])
                byte_next = head_job.d1;
            else
            begin
                stat_next = 1'b1;
                code_next = head_job.status;
                len_next  = head_job.length;
            end
            done_next = sel_last ? '0 : (done_reg | sel);
        end
        else if (!out_stall)
            valid_next = 1'b0;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            done_reg  <= done_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        stat_reg <= stat_next;
        code_reg <= code_next;
        len_reg  <= len_next;
        last_reg <= last_next;
    end

endmodule
